### src/tscd_pkg.sv
// shared types for the time series chunk decoder
`default_nettype none
package tscd_pkg;

  typedef struct packed {
    logic load;
    logic step;
    logic flush;
  } tscd_cmd_t;

  typedef struct packed {
    logic pend_v;
    logic out_free;
  } tscd_stat_t;

  typedef struct packed {
    logic [63:0] sample_time;
    logic [63:0] sample_value_bits;
    logic        chunk_done;
    logic        fault;
  } tscd_res_t;

endpackage
`default_nettype wire

### src/tscd_if.sv
// item channel interfaces for input bytes and decoded samples
`default_nettype none
interface tscd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_start;
  modport source (output valid, output data_byte, output chunk_start, input ready);
  modport sink (input valid, input data_byte, input chunk_start, output ready);
endinterface

interface tscd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] sample_time;
  logic [63:0] sample_value_bits;
  logic        chunk_done;
  logic        fault;
  logic        run_last;
  modport source (output valid, output sample_time, output sample_value_bits,
                  output chunk_done, output fault, output run_last, input ready);
  modport sink (input valid, input sample_time, input sample_value_bits,
                input chunk_done, input fault, input run_last, output ready);
endinterface
`default_nettype wire

### src/tscd_ctrl.sv
// controller: byte acceptance, per-bit stepping and end-of-byte flush
`default_nettype none
module tscd_ctrl
  import tscd_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  tscd_stat_t stat,
  output tscd_cmd_t  cmd
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FLUSH} state_t;

  state_t     state_r, state_nxt;
  logic [2:0] bit_r, bit_nxt;

  always_comb begin
    state_nxt = state_r;
    bit_nxt   = bit_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          bit_nxt   = 3'd0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!stat.pend_v || stat.out_free) begin
          cmd.step = 1'b1;
          bit_nxt  = bit_r + 3'd1;
          if (bit_r == 3'd7) state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!stat.pend_v) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      bit_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      bit_r   <= bit_nxt;
    end
  end

endmodule
`default_nettype wire

### src/tscd_dp.sv
// datapath: bit-serial decode state, pending result and output register
`default_nettype none
module tscd_dp
  import tscd_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  tscd_cmd_t   cmd,
  output tscd_stat_t  stat,
  input  wire  [7:0]  in_data_byte,
  input  wire         in_chunk_start,
  output tscd_res_t   out_res,
  output logic        out_run_last,
  output logic        out_valid,
  input  wire         out_ready
);

  typedef enum logic [3:0] {
    PH_COUNT, PH_T0, PH_V0, PH_D1, PH_VCTL, PH_VREUSE, PH_VLEAD, PH_VWID,
    PH_VBITS, PH_DODPRE, PH_DODBITS, PH_DONE, PH_FAULT
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [15:0] total_r, total_nxt;
  logic [15:0] done_r, done_nxt;
  logic [5:0]  lz_r, lz_nxt;
  logic [6:0]  tz_r, tz_nxt;
  logic [63:0] tnow_r, tnow_nxt;
  logic [63:0] tstep_r, tstep_nxt;
  logic [63:0] val_r, val_nxt;
  logic [3:0]  pre_r, pre_nxt;
  logic [6:0]  vsh_r, vsh_nxt;
  logic [7:0]  byte_r;

  tscd_res_t   pend_r, res;
  logic        pend_v_r;
  logic        out_v_r;
  tscd_res_t   out_r;
  logic        out_last_r;

  logic        b;
  logic [63:0] acc_sh;
  logic [6:0]  cnt_inc;
  logic [63:0] var_or;
  logic [6:0]  wid;
  logic [7:0]  lsum;
  logic [6:0]  used;
  logic [6:0]  mbits;
  logic [6:0]  sz;
  logic [63:0] dod;
  logic        emit, from_v0, flt, last;

  assign b       = byte_r[7];
  assign acc_sh  = {acc_r[62:0], b};
  assign cnt_inc = cnt_r + 7'd1;
  assign var_or  = {57'd0, acc_sh[6:0]} << vsh_r[5:0];
  assign wid     = (acc_sh[5:0] == 6'd0) ? 7'd64 : {1'b0, acc_sh[5:0]};
  assign lsum    = {2'b0, lz_r} + {1'b0, wid};
  assign used    = {1'b0, lz_r} + tz_r;
  assign mbits   = (used >= 7'd64) ? 7'd1 : 7'd64 - used;

  always_comb begin
    case (pre_r)
      4'h2:    sz = 7'd14;
      4'h6:    sz = 7'd17;
      4'he:    sz = 7'd20;
      default: sz = 7'd64;
    endcase
    dod = acc_sh;
    case (pre_r)
      4'h2: if (acc_sh[13:0] > 14'h2000) dod = acc_sh - 64'h4000;
      4'h6: if (acc_sh[16:0] > 17'h10000) dod = acc_sh - 64'h20000;
      4'he: if (acc_sh[19:0] > 20'h80000) dod = acc_sh - 64'h100000;
      default: dod = acc_sh;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    total_nxt = total_r;
    done_nxt  = done_r;
    lz_nxt    = lz_r;
    tz_nxt    = tz_r;
    tnow_nxt  = tnow_r;
    tstep_nxt = tstep_r;
    val_nxt   = val_r;
    pre_nxt   = pre_r;
    vsh_nxt   = vsh_r;
    emit      = 1'b0;
    from_v0   = 1'b0;
    flt       = 1'b0;
    last      = 1'b0;
    res       = '0;
    unique case (phase_r)
      PH_COUNT: begin
        acc_nxt = acc_sh;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= 7'd16) begin
          acc_nxt   = '0;
          cnt_nxt   = '0;
          total_nxt = acc_sh[15:0];
          phase_nxt = (acc_sh[15:0] != 16'd0) ? PH_T0 : PH_DONE;
          vsh_nxt   = '0;
        end
      end
      PH_T0, PH_D1: begin
        acc_nxt = acc_sh;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= 7'd8) begin
          acc_nxt = '0;
          cnt_nxt = '0;
          if (vsh_r >= 7'd63) begin
            if (acc_sh[7:0] > 8'd1) begin
              flt = 1'b1;
            end else if (phase_r == PH_T0) begin
              tnow_nxt  = tnow_r | {acc_sh[0], 63'd0};
              tnow_nxt  = tnow_nxt[0] ? ~{1'b0, tnow_nxt[63:1]} : {1'b0, tnow_nxt[63:1]};
              phase_nxt = PH_V0;
            end else begin
              tstep_nxt = tstep_r | {acc_sh[0], 63'd0};
              tnow_nxt  = tnow_r + tstep_nxt;
              phase_nxt = PH_VCTL;
            end
          end else begin
            vsh_nxt = vsh_r + 7'd7;
            if (phase_r == PH_T0) begin
              tnow_nxt = tnow_r | var_or;
              if (!acc_sh[7]) begin
                tnow_nxt  = tnow_nxt[0] ? ~{1'b0, tnow_nxt[63:1]} : {1'b0, tnow_nxt[63:1]};
                phase_nxt = PH_V0;
              end
            end else begin
              tstep_nxt = tstep_r | var_or;
              if (!acc_sh[7]) begin
                tnow_nxt  = tnow_r + tstep_nxt;
                phase_nxt = PH_VCTL;
              end
            end
          end
        end
      end
      PH_V0: begin
        acc_nxt = acc_sh;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= 7'd64) begin
          acc_nxt   = '0;
          cnt_nxt   = '0;
          val_nxt   = acc_sh;
          vsh_nxt   = '0;
          tstep_nxt = '0;
          emit      = 1'b1;
          from_v0   = 1'b1;
        end
      end
      PH_VCTL: begin
        if (b) phase_nxt = PH_VREUSE;
        else emit = 1'b1;
      end
      PH_VREUSE: begin
        acc_nxt   = '0;
        cnt_nxt   = '0;
        phase_nxt = b ? PH_VLEAD : PH_VBITS;
      end
      PH_VLEAD: begin
        acc_nxt = acc_sh;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= 7'd5) begin
          acc_nxt   = '0;
          cnt_nxt   = '0;
          lz_nxt    = {1'b0, acc_sh[4:0]};
          phase_nxt = PH_VWID;
        end
      end
      PH_VWID: begin
        acc_nxt = acc_sh;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= 7'd6) begin
          acc_nxt = '0;
          cnt_nxt = '0;
          if (lsum > 8'd64) begin
            flt = 1'b1;
          end else begin
            tz_nxt    = 7'd64 - lsum[6:0];
            phase_nxt = PH_VBITS;
          end
        end
      end
      PH_VBITS: begin
        acc_nxt = acc_sh;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= mbits) begin
          acc_nxt = '0;
          cnt_nxt = '0;
          val_nxt = val_r ^ (acc_sh << tz_r[5:0]);
          emit    = 1'b1;
        end
      end
      PH_DODPRE: begin
        pre_nxt = {pre_r[2:0], b};
        cnt_nxt = cnt_inc;
        if (!b || cnt_inc >= 7'd4) begin
          cnt_nxt = '0;
          acc_nxt = '0;
          if ({pre_r[2:0], b} == 4'h0) begin
            tnow_nxt  = tnow_r + tstep_r;
            phase_nxt = PH_VCTL;
          end else begin
            phase_nxt = PH_DODBITS;
          end
        end
      end
      PH_DODBITS: begin
        acc_nxt = acc_sh;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= sz) begin
          acc_nxt   = '0;
          cnt_nxt   = '0;
          tstep_nxt = tstep_r + dod;
          tnow_nxt  = tnow_r + tstep_nxt;
          phase_nxt = PH_VCTL;
        end
      end
      PH_DONE, PH_FAULT: begin
      end
      default: phase_nxt = PH_FAULT;
    endcase

    if (flt) begin
      phase_nxt   = PH_FAULT;
      res.fault   = 1'b1;
    end
    if (emit) begin
      done_nxt              = done_r + 16'd1;
      last                  = (done_nxt == total_r);
      res.sample_time       = tnow_nxt;
      res.sample_value_bits = val_nxt;
      res.chunk_done        = last;
      if (last) begin
        phase_nxt = PH_DONE;
      end else begin
        phase_nxt = from_v0 ? PH_D1 : PH_DODPRE;
        pre_nxt   = '0;
        cnt_nxt   = '0;
        acc_nxt   = '0;
      end
    end
  end

  assign stat.pend_v   = pend_v_r;
  assign stat.out_free = !out_v_r || out_ready;
  assign out_res       = out_r;
  assign out_run_last  = out_last_r;
  assign out_valid     = out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_COUNT;
      acc_r    <= '0;
      cnt_r    <= '0;
      total_r  <= '0;
      done_r   <= '0;
      lz_r     <= '0;
      tz_r     <= '0;
      tnow_r   <= '0;
      tstep_r  <= '0;
      val_r    <= '0;
      pre_r    <= '0;
      vsh_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        byte_r <= in_data_byte;
        if (in_chunk_start) begin
          phase_r <= PH_COUNT;
          acc_r   <= '0;
          cnt_r   <= '0;
          total_r <= '0;
          done_r  <= '0;
          lz_r    <= '0;
          tz_r    <= '0;
          tnow_r  <= '0;
          tstep_r <= '0;
          val_r   <= '0;
          pre_r   <= '0;
          vsh_r   <= '0;
        end
      end
      if (cmd.step) begin
        byte_r  <= {byte_r[6:0], 1'b0};
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        cnt_r   <= cnt_nxt;
        total_r <= total_nxt;
        done_r  <= done_nxt;
        lz_r    <= lz_nxt;
        tz_r    <= tz_nxt;
        tnow_r  <= tnow_nxt;
        tstep_r <= tstep_nxt;
        val_r   <= val_nxt;
        pre_r   <= pre_nxt;
        vsh_r   <= vsh_nxt;
        if (emit || flt) begin
          pend_r   <= res;
          pend_v_r <= 1'b1;
          if (pend_v_r) begin
            out_r      <= pend_r;
            out_last_r <= 1'b0;
          end
        end
      end
      if (cmd.flush) begin
        out_r      <= pend_r;
        out_last_r <= 1'b1;
        pend_v_r   <= 1'b0;
      end
      if ((cmd.step && (emit || flt) && pend_v_r) || cmd.flush) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### src/time_series_chunk_decoder_top.sv
// top level of the time series chunk decoder
// usage:
//   in_ch carries one payload byte per item, most significant bit decoded first;
//   chunk_start on a byte clears all decoder state before that byte is decoded.
//   out_ch carries decoded samples (time, value bits, chunk_done, fault) and
//   run_last, set on the last sample caused by a given input byte.
// timing:
//   a byte is accepted, then its eight bits are decoded one bit per cycle by the
//   shared bit-step unit while decoding is not paused (see stalls), then the held
//   sample of that byte is flushed.
//   a sample does not appear on out_ch together with the bit that ends it,
//   since each sample waits in a one-deep holding register until the next
//   sample of the same byte or the end of the byte fixes its run_last.
// reset:
//   rst_n clears the decoder to the sample count phase and empties the output.
// stalls:
//   when out_ch is not ready, bit decoding pauses while a sample is held and the
//   output register is full; in_ch stays not ready until the byte is finished.
`default_nettype none
module time_series_chunk_decoder_top
  import tscd_pkg::*;
(
  input wire         clk,
  input wire         rst_n,
  tscd_in_if.sink    in_ch,
  tscd_out_if.source out_ch
);

  tscd_cmd_t  cmd;
  tscd_stat_t stat;
  tscd_res_t  res;

  tscd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tscd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_data_byte   (in_ch.data_byte),
    .in_chunk_start (in_ch.chunk_start),
    .out_res        (res),
    .out_run_last   (out_ch.run_last),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready)
  );

  assign out_ch.sample_time       = res.sample_time;
  assign out_ch.sample_value_bits = res.sample_value_bits;
  assign out_ch.chunk_done        = res.chunk_done;
  assign out_ch.fault             = res.fault;

endmodule
`default_nettype wire
